// ===== src/pse_pkg.sv =====
package pse_pkg;
  localparam int StackDepth = 16;
  localparam int AddrW = $clog2(StackDepth);
  localparam int SpW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_NEG = 3'd1, OP_ADD = 3'd2, OP_SUB = 3'd3,
    OP_MUL = 3'd4, OP_DIV = 3'd5, OP_MOD = 3'd6, OP_END = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_UNUSED = 3'd2, ST_DIVZERO = 3'd3,
    ST_NEGMOD = 3'd4, ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_WRITE, S_OUT
  } state_t;

  // request and response between control and the iterative arithmetic unit
  typedef struct packed {
    logic start;
    logic is_mul;
    logic is_mod;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;
endpackage

// ===== src/pse_stack_ram.sv =====
module pse_stack_ram #(
  parameter int Depth = 16,
  parameter int Width = 64,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [Width-1:0] rdata_a,
  output logic [Width-1:0] rdata_b
);
  logic [Width-1:0] mem [Depth];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== src/pse_alu.sv =====
module pse_alu (
  input  logic             clk,
  input  logic             rst,
  input  pse_pkg::alu_req_t req,
  input  logic [63:0]      lhs,
  input  logic [63:0]      rhs,
  output pse_pkg::alu_rsp_t rsp,
  output logic [63:0]      res
);
  import pse_pkg::*;

  logic        busy;
  logic        is_mul;
  logic        neg_q;
  logic [6:0]  cnt;
  logic [63:0] acc;
  logic [63:0] a;
  logic [63:0] b;
  logic [64:0] rem;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        keep_rem;

  assign rem_sh = {rem[63:0], a[63]};
  assign diff = rem_sh - {1'b0, b};

  // one bit per cycle: shift-add multiply or restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        is_mul <= req.is_mul;
        keep_rem <= req.is_mod;
        neg_q <= lhs[63] ^ rhs[63];
        acc <= 64'd0;
        rem <= 65'd0;
        if (req.is_mul) begin
          a <= lhs;
          b <= rhs;
        end else begin
          a <= lhs[63] ? -lhs : lhs;
          b <= rhs[63] ? -rhs : rhs;
        end
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (is_mul) begin
          if (b[0]) acc <= acc + a;
          a <= a << 1;
          b <= b >> 1;
        end else begin
          a <= {a[62:0], ~diff[64]};
          rem <= diff[64] ? rem_sh : diff;
        end
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_mul) res = acc;
    else if (keep_rem) res = rem[63:0];
    else res = neg_q ? -a : a;
  end
endmodule

// ===== src/postfix_stack_evaluator.sv =====
// Postfix evaluator: one token at a time on a 16-entry operand stack held in a
// two-read-port RAM. Negate, add and subtract are computed directly; multiply,
// divide and modulo go through the one-bit-per-cycle arithmetic unit.
// An end token gives one item of value and status, held until the receiver
// takes it; other tokens give none. Errors latch until end; end clears the
// stack.
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic signed [63:0] token_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] result_value,
  output logic [2:0]  status
);
  import pse_pkg::*;

  state_t state, state_next;
  logic [SpW-1:0] sp;
  logic [2:0]     err;
  logic           seen;
  op_t            cur_op;
  logic [63:0]    cur_val;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [63:0]      wdata;
  logic [AddrW-1:0] ra;
  logic [AddrW-1:0] rb;
  logic [63:0]      rd_r;
  logic [63:0]      rd_l;
  alu_req_t         req;
  alu_rsp_t         rsp;
  logic [63:0]      alu_res;
  logic [63:0]      simple_res;

  logic [SpW-1:0] sp_m1;
  logic [SpW-1:0] sp_m2;
  assign sp_m1 = sp - SpW'(1);
  assign sp_m2 = sp - SpW'(2);
  assign ra = sp_m1[AddrW-1:0];
  assign rb = sp_m2[AddrW-1:0];

  pse_stack_ram #(.Depth(StackDepth), .Width(64)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rd_r), .rdata_b(rd_l)
  );

  pse_alu u_alu (
    .clk(clk), .rst(rst), .req(req), .lhs(rd_l), .rhs(rd_r),
    .rsp(rsp), .res(alu_res)
  );

  // read at address zero for the end token goes through port a when sp is 1
  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        priority if (cur_op == OP_END) state_next = S_OUT;
        else if (err != ST_OK || cur_op == OP_PUSH) state_next = S_IDLE;
        else if (cur_op == OP_NEG && sp == SpW'(0)) state_next = S_IDLE;
        else if (cur_op != OP_NEG && sp < SpW'(2)) state_next = S_IDLE;
        else if (cur_op == OP_NEG || cur_op == OP_ADD || cur_op == OP_SUB)
          state_next = S_WRITE;
        else if (cur_op != OP_MUL && rd_r == 64'd0) state_next = S_IDLE;
        else if (cur_op == OP_MOD && (rd_r[63] || rd_l[63])) state_next = S_IDLE;
        else state_next = S_WAIT;
      end
      S_WAIT: if (rsp.done) state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (cur_op)
      OP_NEG: simple_res = -rd_r;
      OP_ADD: simple_res = rd_l + rd_r;
      OP_SUB: simple_res = rd_l - rd_r;
      default: simple_res = alu_res;
    endcase
  end

  // outputs: ram write and unit start
  always_comb begin
    we = 1'b0;
    waddr = ra;
    wdata = simple_res;
    req = '0;
    if (state == S_EXEC && cur_op == OP_PUSH && err == ST_OK &&
        sp < SpW'(StackDepth)) begin
      we = 1'b1;
      waddr = sp[AddrW-1:0];
      wdata = cur_val;
    end
    if (state == S_EXEC && state_next == S_WAIT) begin
      req.start = 1'b1;
      req.is_mul = (cur_op == OP_MUL);
      req.is_mod = (cur_op == OP_MOD);
    end
    if (state == S_WRITE) begin
      we = 1'b1;
      waddr = (cur_op == OP_NEG) ? ra : rb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      err <= ST_OK;
      seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && cur_op != OP_END) begin
        seen <= 1'b1;
        if (err == ST_OK) begin
          if (cur_op == OP_PUSH) begin
            if (sp < SpW'(StackDepth)) sp <= sp + SpW'(1);
            else err <= ST_OVERFLOW;
          end else if (cur_op == OP_NEG) begin
            if (sp == SpW'(0)) err <= ST_UNUSED;
          end else if (sp < SpW'(2)) err <= ST_UNUSED;
          else if ((cur_op == OP_DIV || cur_op == OP_MOD) && rd_r == 64'd0)
            err <= ST_DIVZERO;
          else if (cur_op == OP_MOD && (rd_r[63] || rd_l[63])) err <= ST_NEGMOD;
        end
      end
      if (state == S_WRITE && cur_op != OP_NEG) sp <= sp_m1;
      if (state == S_OUT && out_ready) begin
        sp <= '0;
        err <= ST_OK;
        seen <= 1'b0;
      end
    end
  end

  // latch the token and form the end item
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_op <= op_t'(op);
      cur_val <= token_value;
    end
    if (state == S_EXEC && cur_op == OP_END) begin
      result_value <= 64'sd0;
      priority if (err != ST_OK) status <= err;
      else if (!seen) status <= ST_EMPTY;
      else if (sp != SpW'(1)) status <= ST_UNUSED;
      else begin
        status <= ST_OK;
        result_value <= rd_r;
      end
    end
  end

  assign out_valid = (state == S_OUT);

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SpW'(StackDepth)) else $error("stack pointer out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (sp == '0 && err == ST_OK))
    else $error("end did not clear");
  a_wait_start: assert property (@(posedge clk) disable iff (rst)
    req.start |=> state == S_WAIT) else $error("unit start without wait");
endmodule
